### rtl/serial_feedback_frame_sync_assert.svh
// Assertion macros for the RTL
`ifndef SERIAL_FEEDBACK_FRAME_SYNC_ASSERT_SVH
`define SERIAL_FEEDBACK_FRAME_SYNC_ASSERT_SVH

// same-cycle implication
`define SFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sfs_pkg.sv
`timescale 1ns / 1ps

package sfs_pkg;

    localparam int unsigned FRAME_BYTES = 18;
    localparam int unsigned FRAME_WORDS = 9;
    localparam int unsigned SUM_WORDS   = 8;
    localparam int unsigned FILL_W      = 5;
    localparam logic [15:0] START_WORD  = 16'hABCD;
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_BYTES - 1);

    typedef struct packed {
        logic [15:0] command_one;
        logic [15:0] command_two;
        logic [15:0] speed_right;
        logic [15:0] speed_left;
        logic [15:0] battery_voltage;
        logic [15:0] board_temperature;
        logic [15:0] led_word;
    } t_frame;

    typedef struct packed {
        logic              hit;
        logic [FILL_W-1:0] fill;
    } t_fsts;

endpackage

### rtl/sfs_front.sv
`timescale 1ns / 1ps

module sfs_front
    import sfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_space,
    output logic       o_push,
    output t_frame     o_frame,
    output t_fsts      o_stat
);

    logic [7:0]        r_win [FRAME_BYTES];
    logic [7:0]        n_win [FRAME_BYTES];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [15:0]       w [FRAME_WORDS];
    logic [15:0]       sum;
    logic              acc;
    logic              hit;

    assign o_ready = i_space;
    assign acc     = i_valid && i_space;

    always_comb begin
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            n_win[i] = r_win[i+1];
        end
        n_win[FRAME_BYTES-1] = i_data_byte;
        for (int k = 0; k < FRAME_WORDS; k++) begin
            w[k] = {n_win[2*k+1], n_win[2*k]};
        end
        sum = '0;
        for (int k = 0; k < SUM_WORDS; k++) begin
            sum = sum ^ w[k];
        end
        hit = (r_fill == FILL_LAST) && (w[0] == START_WORD) && (sum == w[FRAME_WORDS-1]);
        if (hit) begin
            n_fill = '0;
        end else if (r_fill == FILL_LAST) begin
            n_fill = FILL_LAST;
        end else begin
            n_fill = r_fill + 1'b1;
        end
    end

    assign o_push  = acc && hit;
    assign o_frame = '{w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
    assign o_stat  = '{hit, r_fill};

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (acc) begin
            r_fill <= n_fill;
        end
    end

endmodule

### rtl/sfs_queue.sv
`timescale 1ns / 1ps

module sfs_queue
    import sfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame     i_frame,
    output logic       o_space,
    output logic       o_valid,
    input  logic       i_pop,
    output t_frame     o_frame,
    output logic [1:0] o_level
);

    t_frame     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_level;

    assign o_space = (r_level != 2'd2);
    assign o_valid = (r_level != 2'd0);
    assign o_frame = r_mem[r_rptr];
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

### rtl/sfs_back.sv
`timescale 1ns / 1ps

module sfs_back
    import sfs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_frame i_frame,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_frame o_frame
);

    logic   r_valid;
    t_frame r_frame;
    logic   load;

    assign load    = i_valid && (!r_valid || i_ready);
    assign o_pop   = load;
    assign o_valid = r_valid;
    assign o_frame = r_frame;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_frame <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

### rtl/serial_feedback_frame_sync.sv
`timescale 1ns / 1ps
// channel   valid     ready     payload
// in        i_valid   o_ready   i_data_byte
// out       o_valid   i_ready   o_command_one .. o_led_word
//
// One byte per cycle while o_ready is high; the window shift and XOR check run in the accept cycle.
// A frame is queued when its last byte is accepted, then loaded into the output register.
// Reset is synchronous, active low; it empties the window, queue and output stage.
// A two-entry frame queue sits between the byte side and the output register;
// o_ready drops only while that queue is full.

module serial_feedback_frame_sync
    import sfs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_command_one,
    output logic signed [15:0] o_command_two,
    output logic signed [15:0] o_speed_right,
    output logic signed [15:0] o_speed_left,
    output logic signed [15:0] o_battery_voltage,
    output logic signed [15:0] o_board_temperature,
    output logic        [15:0] o_led_word
);

`include "serial_feedback_frame_sync_assert.svh"

    logic       space;
    logic       push;
    t_frame     push_frame;
    t_fsts      fstat;
    logic       q_valid;
    logic       pop;
    t_frame     q_frame;
    logic [1:0] q_level;
    t_frame     out_frame;

    sfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_space     (space),
        .o_push      (push),
        .o_frame     (push_frame),
        .o_stat      (fstat)
    );

    sfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .o_space (space),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_frame (q_frame),
        .o_level (q_level)
    );

    sfs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_frame (q_frame),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_frame (out_frame)
    );

    assign o_command_one       = out_frame.command_one;
    assign o_command_two       = out_frame.command_two;
    assign o_speed_right       = out_frame.speed_right;
    assign o_speed_left        = out_frame.speed_left;
    assign o_battery_voltage   = out_frame.battery_voltage;
    assign o_board_temperature = out_frame.board_temperature;
    assign o_led_word          = out_frame.led_word;

    `SFS_ASSERT_IMP(a_full_stalls, i_clk, i_rst_n, q_level == 2'd2, !o_ready,
        "queue full but input ready")
    `SFS_ASSERT_NXT(a_hit_clears, i_clk, i_rst_n, i_valid && o_ready && fstat.hit,
        fstat.fill == '0, "window not emptied after frame")
    `SFS_ASSERT_IMP(a_out_from_queue, i_clk, i_rst_n, $rose(o_valid),
        $past(q_level) != 2'd0, "output word without queued frame")

endmodule

### test/serial_feedback_frame_sync_tb.sv
`timescale 1ns / 1ps

module serial_feedback_frame_sync_tb;
    import sfs_pkg::*;

    localparam int N_ROWS      = 20;
    localparam int RAND_BYTES  = 1950;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [7:0] data;
        logic       has_frame;
        t_frame     frame;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_data_byte;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_command_one;
    logic signed [15:0] o_command_two;
    logic signed [15:0] o_speed_right;
    logic signed [15:0] o_speed_left;
    logic signed [15:0] o_battery_voltage;
    logic signed [15:0] o_board_temperature;
    logic        [15:0] o_led_word;

    serial_feedback_frame_sync uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_command_one       (o_command_one),
        .o_command_two       (o_command_two),
        .o_speed_right       (o_speed_right),
        .o_speed_left        (o_speed_left),
        .o_battery_voltage   (o_battery_voltage),
        .o_board_temperature (o_board_temperature),
        .o_led_word          (o_led_word)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // byte window shadow
    logic [7:0]  rx_window [FRAME_BYTES];
    int unsigned rx_fill;
    t_frame      pending_frames [$];

    int err_cnt;
    int bytes_sent;
    int frames_seen;
    int bad_frames;
    int noise_bytes;
    int cycle_cnt;
    int burst_left;
    int stall_pct;
    bit calm;

    string field_names [7] = '{"command_one", "command_two", "speed_right", "speed_left",
                               "battery_voltage", "board_temperature", "led_word"};

    function automatic bit frame_sync_step(input logic [7:0] b, output t_frame fr);
        logic [15:0] w [FRAME_WORDS];
        logic [15:0] chk;
        fr = '0;
        if (rx_fill >= FRAME_BYTES) rx_fill = 0;
        rx_window[rx_fill] = b;
        rx_fill++;
        if (rx_fill < FRAME_BYTES) return 1'b0;
        chk = '0;
        for (int k = 0; k < FRAME_WORDS; k++) w[k] = {rx_window[2*k+1], rx_window[2*k]};
        for (int k = 0; k < SUM_WORDS; k++) chk ^= w[k];
        if (w[0] == START_WORD && chk == w[FRAME_WORDS-1]) begin
            fr = {w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
            rx_fill = 0;
            return 1'b1;
        end
        for (int k = 0; k < FRAME_BYTES - 1; k++) rx_window[k] = rx_window[k+1];
        rx_fill = FRAME_BYTES - 1;
        return 1'b0;
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_frame tf);
        int     gap;
        bit     hit;
        t_frame fr;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        hit = frame_sync_step(b, fr);
        if (typed) pending_frames.push_back(tf);
        else if (hit) pending_frames.push_back(fr);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_frames();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_frames.size() != 0);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(input bit corrupt);
        logic [15:0] w [FRAME_WORDS];
        logic [7:0]  fb [FRAME_BYTES];
        int          pos;
        w[0] = START_WORD;
        w[FRAME_WORDS-1] = START_WORD;
        for (int k = 1; k < SUM_WORDS; k++) begin
            w[k] = rand_word();
            w[FRAME_WORDS-1] ^= w[k];
        end
        for (int k = 0; k < FRAME_WORDS; k++) begin
            fb[2*k]   = w[k][7:0];
            fb[2*k+1] = w[k][15:8];
        end
        if (corrupt) begin
            pos = $urandom_range(0, FRAME_BYTES - 1);
            fb[pos][$urandom_range(0, 7)] ^= 1'b1;
            bad_frames++;
        end
        for (int k = 0; k < FRAME_BYTES; k++) send_byte(fb[k], 1'b0, '0);
    endtask

    // receiver stalls; the stall density is periodically redrawn at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (cycle_cnt % 300 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            end
            i_ready <= calm || ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_frame got;
        t_frame want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d frames outstanding",
                     cycle_cnt, pending_frames.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_command_one, o_command_two, o_speed_right, o_speed_left,
                   o_battery_voltage, o_board_temperature, o_led_word};
            frames_seen++;
            if (pending_frames.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("%0t: unexpected frame %h", $realtime, got);
            end else begin
                want = pending_frames.pop_front();
                for (int k = 0; k < 7; k++) begin
                    if (got[16*(6-k) +: 16] !== want[16*(6-k) +: 16]) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: %s expected %h got %h", $realtime,
                                     field_names[k], want[16*(6-k) +: 16],
                                     got[16*(6-k) +: 16]);
                    end
                end
            end
        end
    end

    initial begin
        t_row   rows [N_ROWS];
        int     pick;
        int     n;
        bit     mid_drained;
        logic [7:0] nb;

        // two junk bytes, then a frame with extreme payload words
        rows = '{
            '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0},
            '{8'hCD, 1'b0, '0}, '{8'hAB, 1'b0, '0},
            '{8'h00, 1'b0, '0}, '{8'h80, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'h7F, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'hFE, 1'b0, '0}, '{8'hFF, 1'b0, '0},
            '{8'hA5, 1'b0, '0}, '{8'h5A, 1'b0, '0},
            '{8'h97, 1'b0, '0},
            '{8'h0E, 1'b1, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
                            16'h0001, 16'hFFFE, 16'h5AA5}}
        };

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = 8'h00;
        i_ready     = 1'b0;
        err_cnt     = 0;
        bytes_sent  = 0;
        frames_seen = 0;
        bad_frames  = 0;
        noise_bytes = 0;
        cycle_cnt   = 0;
        burst_left  = 0;
        stall_pct   = 0;
        calm        = 1'b0;
        mid_drained = 1'b0;
        rx_fill     = 0;
        for (int k = 0; k < FRAME_BYTES; k++) rx_window[k] = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_ROWS; r++) send_byte(rows[r].data, rows[r].has_frame, rows[r].frame);
        drain_frames();

        while (bytes_sent < N_ROWS + RAND_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(1'b0);
            end else if (pick < 82) begin
                send_frame(1'b1);
            end else begin
                n = $urandom_range(1, 9);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0: nb = 8'hCD;
                        1: nb = 8'hAB;
                        default: nb = 8'($urandom);
                    endcase
                    send_byte(nb, 1'b0, '0);
                    noise_bytes++;
                end
            end
            if (!mid_drained && bytes_sent > 1000) begin
                drain_frames();
                mid_drained = 1'b1;
            end
        end

        i_valid <= 1'b0;
        while (pending_frames.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("Fed %0d bytes (%0d noise, %0d corrupted frames) under random gaps and stalls",
                 bytes_sent, noise_bytes, bad_frames);
        $display("Compared %0d frames, %0d field mismatches", frames_seen, err_cnt);
        if (err_cnt == 0 && pending_frames.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/sfs_pkg.sv
rtl/sfs_front.sv
rtl/sfs_queue.sv
rtl/sfs_back.sv
rtl/serial_feedback_frame_sync.sv
test/serial_feedback_frame_sync_tb.sv
